// ----- sv/utf8dv_pkg.sv -----
// Shared types, constants and sequence checks for the UTF-8 decoder and validator.
package utf8dv_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STRAY    = 3'd1,
    ST_MISSING  = 3'd2,
    ST_SURR     = 3'd3,
    ST_OVERLONG = 3'd4,
    ST_RANGE    = 3'd5,
    ST_BADLEAD  = 3'd6
  } status_e;

  typedef struct packed {
    logic [20:0] scalar_val;
    status_e     status;
    logic [2:0]  bytes_used;
    logic [31:0] raw_bytes;
    logic        last_of_run;
  } res_t;

  localparam logic [7:0]  LeadC0      = 8'hC0;
  localparam logic [7:0]  LeadC1      = 8'hC1;
  localparam logic [7:0]  LeadE0      = 8'hE0;
  localparam logic [7:0]  LeadF0      = 8'hF0;
  localparam logic [7:0]  LeadF8      = 8'hF8;
  localparam logic [7:0]  MinAfterE0  = 8'hA0;
  localparam logic [7:0]  MinAfterF0  = 8'h90;
  localparam logic [20:0] MaxCodePt   = 21'h10FFFF;
  localparam logic [4:0]  SurrTop     = 5'b11011;

  function automatic res_t mk_res(logic [20:0] cp, status_e st, logic [2:0] used,
                                  logic [31:0] raw);
    res_t r;
    r.scalar_val  = cp;
    r.status      = st;
    r.bytes_used  = used;
    r.raw_bytes   = raw;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Decodes a complete sequence of 2, 3 or 4 bytes and grades it.
  function automatic res_t finish_seq(logic [2:0] needed, logic [31:0] raw);
    logic [20:0] cp;
    status_e     st;
    st = ST_OK;
    case (needed)
      3'd2: begin
        cp = {10'd0, raw[4:0], raw[13:8]};
        if (raw[7:0] == LeadC0 || raw[7:0] == LeadC1) st = ST_OVERLONG;
      end
      3'd3: begin
        cp = {5'd0, raw[3:0], raw[13:8], raw[21:16]};
        if (cp[15:11] == SurrTop) st = ST_SURR;
        else if (raw[7:0] == LeadE0 && raw[15:8] < MinAfterE0) st = ST_OVERLONG;
      end
      default: begin
        cp = {raw[2:0], raw[13:8], raw[21:16], raw[29:24]};
        if (cp > MaxCodePt) st = ST_RANGE;
        else if (raw[7:0] == LeadF0 && raw[15:8] < MinAfterF0) st = ST_OVERLONG;
      end
    endcase
    return mk_res(cp, st, needed, raw);
  endfunction

endpackage

// ----- sv/utf8dv_decode.sv -----
// Sequence state and per-byte decode logic, giving up to two results per byte.
module utf8dv_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              eor_i,
  output logic [1:0]        num_o,
  output utf8dv_pkg::res_t  res0_o,
  output utf8dv_pkg::res_t  res1_o
);

  logic [23:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  need_q, need_d;

  logic              cont;
  logic [2:0]        cnt_p1;
  logic [31:0]       raw_ext;
  utf8dv_pkg::res_t  fresh;
  logic              fresh_v;

  assign cont   = (byte_i[7:6] == 2'b10);
  assign cnt_p1 = {1'b0, cnt_q} + 3'd1;

  always_comb begin
    case (cnt_q)
      2'd1:    raw_ext = {16'd0, byte_i, held_q[7:0]};
      2'd2:    raw_ext = {8'd0, byte_i, held_q[15:0]};
      default: raw_ext = {byte_i, held_q};
    endcase
  end

  always_comb begin
    held_d  = held_q;
    cnt_d   = cnt_q;
    need_d  = need_q;
    num_o   = 2'd0;
    res0_o  = '0;
    res1_o  = '0;
    fresh   = '0;
    fresh_v = 1'b0;
    if (cnt_q != 2'd0 && cont) begin
      if (cnt_p1 >= need_q) begin
        res0_o = utf8dv_pkg::finish_seq(need_q, raw_ext);
        num_o  = 2'd1;
        held_d = '0;
        cnt_d  = '0;
        need_d = '0;
      end else if (eor_i) begin
        res0_o = utf8dv_pkg::mk_res('0, utf8dv_pkg::ST_MISSING, cnt_p1, raw_ext);
        num_o  = 2'd1;
        held_d = '0;
        cnt_d  = '0;
        need_d = '0;
      end else begin
        held_d = raw_ext[23:0];
        cnt_d  = cnt_p1[1:0];
      end
    end else begin
      // A breaking byte first closes the pending sequence.
      if (cnt_q != 2'd0) begin
        res0_o = utf8dv_pkg::mk_res('0, utf8dv_pkg::ST_MISSING, {1'b0, cnt_q},
                                    {8'd0, held_q});
        num_o  = 2'd1;
        held_d = '0;
        cnt_d  = '0;
        need_d = '0;
      end
      if (!byte_i[7]) begin
        fresh   = utf8dv_pkg::mk_res({13'd0, byte_i}, utf8dv_pkg::ST_OK, 3'd1,
                                     {24'd0, byte_i});
        fresh_v = 1'b1;
      end else if (cont) begin
        fresh   = utf8dv_pkg::mk_res('0, utf8dv_pkg::ST_STRAY, 3'd1, {24'd0, byte_i});
        fresh_v = 1'b1;
      end else if (byte_i >= utf8dv_pkg::LeadF8) begin
        fresh   = utf8dv_pkg::mk_res('0, utf8dv_pkg::ST_BADLEAD, 3'd1, {24'd0, byte_i});
        fresh_v = 1'b1;
      end else if (eor_i) begin
        fresh   = utf8dv_pkg::mk_res('0, utf8dv_pkg::ST_MISSING, 3'd1, {24'd0, byte_i});
        fresh_v = 1'b1;
      end else begin
        need_d = (byte_i < utf8dv_pkg::LeadE0) ? 3'd2 :
                 (byte_i < utf8dv_pkg::LeadF0) ? 3'd3 : 3'd4;
        held_d = {16'd0, byte_i};
        cnt_d  = 2'd1;
      end
      if (fresh_v) begin
        if (num_o == 2'd0) begin
          res0_o = fresh;
          num_o  = 2'd1;
        end else begin
          res1_o = fresh;
          num_o  = 2'd2;
        end
      end
    end
    if (num_o == 2'd1) res0_o.last_of_run = 1'b1;
    if (num_o == 2'd2) res1_o.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
      need_q <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
      need_q <= need_d;
    end
  end

  a_need_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> ((need_q == 3'd2 || need_q == 3'd3 || need_q == 3'd4)
                         && ({1'b0, cnt_q} < need_q)))
    else $error("pending sequence has an inconsistent length");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (need_q == 3'd0 && held_q == 24'd0))
    else $error("sequence state not cleared while idle");

endmodule

// ----- sv/utf8dv_out.sv -----
// Result register with one overflow slot for the second result of a byte.
module utf8dv_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        num_i,
  input  utf8dv_pkg::res_t  res0_i,
  input  utf8dv_pkg::res_t  res1_i,
  input  logic              ready_i,
  output logic              valid_o,
  output utf8dv_pkg::res_t  res_o,
  output logic              free_o
);

  logic             out_v_q, out_v_d;
  logic             ext_v_q, ext_v_d;
  utf8dv_pkg::res_t out_q, out_d;
  utf8dv_pkg::res_t ext_q, ext_d;
  logic             take;

  assign take    = out_v_q && ready_i;
  assign free_o  = !ext_v_q && (!out_v_q || ready_i);
  assign valid_o = out_v_q;
  assign res_o   = out_q;

  always_comb begin
    out_v_d = out_v_q;
    ext_v_d = ext_v_q;
    out_d   = out_q;
    ext_d   = ext_q;
    if (step_i) begin
      case (num_i)
        2'd0: out_v_d = 1'b0;
        2'd1: begin
          out_v_d = 1'b1;
          out_d   = res0_i;
        end
        2'd2: begin
          out_v_d = 1'b1;
          out_d   = res0_i;
          ext_v_d = 1'b1;
          ext_d   = res1_i;
        end
        default: out_v_d = 1'b0;
      endcase
    end else if (take) begin
      if (ext_v_q) begin
        out_d   = ext_q;
        ext_v_d = 1'b0;
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      ext_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      ext_v_q <= ext_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    ext_q <= ext_d;
  end

  a_ext_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_v_q |-> out_v_q)
    else $error("overflow slot filled while result register is empty");

  a_pair_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && num_i == 2'd2) |=> (ext_v_q && out_v_q))
    else $error("second result of a byte was not parked");

endmodule

// ----- sv/utf8_decode_validate_top.sv -----
// Top level of the streaming UTF-8 decoder and validator.
// A byte passes from the input register through the decoder into the result register.
// Throughput: one byte per cycle while m_axis_tready is high; a byte that yields two
// results holds the input until the second result leaves the overflow slot.
// Reset (rst_ni low, asynchronous) drops any pending sequence and empties all
// stages; no clearing pass is needed afterward.
module utf8_decode_validate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
  input  logic        s_axis_tlast,   // end_of_range
  // Decoded results out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // scalar_val[20:0], bytes_used[23:21], raw_bytes[55:24]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast    // last_of_run
);

  // Input register: holds one byte request until the decoder takes it.
  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_eor_q;

  logic             step;
  logic             out_free;
  logic [1:0]       num;
  utf8dv_pkg::res_t res0, res1, res_out;

  // The decoder advances whenever a byte is held and the result side has room
  // for everything it might produce.
  assign step          = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || step;

  always_comb begin
    in_v_d = in_v_q;
    if (s_axis_tvalid && s_axis_tready) in_v_d = 1'b1;
    else if (step) in_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eor_q  <= s_axis_tlast;
    end
  end

  utf8dv_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .eor_i  (in_eor_q),
    .num_o  (num),
    .res0_o (res0),
    .res1_o (res1)
  );

  utf8dv_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .num_i   (num),
    .res0_i  (res0),
    .res1_i  (res1),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out),
    .free_o  (out_free)
  );

  // Pack the result fields onto the stream, first field in the lowest bits.
  assign m_axis_tdata = {res_out.raw_bytes, res_out.bytes_used, res_out.scalar_val};
  assign m_axis_tuser = res_out.status;
  assign m_axis_tlast = res_out.last_of_run;

endmodule
